// File: hw/rtl/dfpm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfpm_pkg
// Shared constants, register map and types of the fuzzy DNA pattern matcher.
// ----------------------------------------------------------------------------
package dfpm_pkg;

	localparam int PATTERN_MAX   = 32;
	localparam int TOLERANCE_MAX = 15;
	localparam int TEXT_MAX      = 1048576;
	localparam int HIST_DEPTH    = PATTERN_MAX + 2 * TOLERANCE_MAX + 1;

	localparam int SYM_W   = 2;
	localparam int NSYM    = 4;
	localparam int LEN_W   = 6;
	localparam int TOL_W   = 4;
	localparam int PAT_W   = 64;
	localparam int EPOS_W  = 20;
	localparam int TOTAL_W = 21;
	localparam int VCNT_W  = $clog2(HIST_DEPTH + 1);
	localparam int OFFS_W  = VCNT_W + 1;

	localparam int APB_AW = 5;
	localparam int APB_DW = 64;

	localparam logic [1:0] REG_PATTERN_LENGTH  = 2'd0;
	localparam logic [1:0] REG_TOLERANCE       = 2'd1;
	localparam logic [1:0] REG_PATTERN_SYMBOLS = 2'd2;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [TOL_W-1:0] tolerance;
		logic [PAT_W-1:0] pattern;
	} cfg_t;

	typedef struct packed {
		logic [EPOS_W-1:0]  end_position;
		logic               has_position;
		logic               matched;
		logic [TOTAL_W-1:0] match_total;
		logic               last;
	} out_item_t;

	typedef logic [HIST_DEPTH-1:0][SYM_W-1:0] hist_t;

endpackage
`default_nettype wire

// File: hw/rtl/dfpm_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfpm_regs
// APB configuration registers; presents the clamped settings to the datapath.
// ----------------------------------------------------------------------------
module dfpm_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dfpm_pkg::APB_AW-1:0]   paddr,
	input  wire logic [dfpm_pkg::APB_DW-1:0]   pwdata,
	output logic      [dfpm_pkg::APB_DW-1:0]   prdata,
	output logic                               pready,
	output dfpm_pkg::cfg_t                     cfg
);

	logic [dfpm_pkg::LEN_W-1:0] length_q;
	logic [dfpm_pkg::TOL_W-1:0] tolerance_q;
	logic [dfpm_pkg::PAT_W-1:0] pattern_q;
	logic [1:0]                 reg_idx;
	logic                       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[dfpm_pkg::APB_AW-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= dfpm_pkg::LEN_W'(1);
			tolerance_q <= '0;
			pattern_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				dfpm_pkg::REG_PATTERN_LENGTH:  length_q    <= pwdata[dfpm_pkg::LEN_W-1:0];
				dfpm_pkg::REG_TOLERANCE:       tolerance_q <= pwdata[dfpm_pkg::TOL_W-1:0];
				dfpm_pkg::REG_PATTERN_SYMBOLS: pattern_q   <= pwdata[dfpm_pkg::PAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			dfpm_pkg::REG_PATTERN_LENGTH:  prdata = dfpm_pkg::APB_DW'(length_q);
			dfpm_pkg::REG_TOLERANCE:       prdata = dfpm_pkg::APB_DW'(tolerance_q);
			dfpm_pkg::REG_PATTERN_SYMBOLS: prdata = dfpm_pkg::APB_DW'(pattern_q);
			default:                       prdata = '0;
		endcase
	end

	always_comb begin
		cfg.pattern   = pattern_q;
		cfg.tolerance = tolerance_q;
		if (length_q == '0) begin
			cfg.length = dfpm_pkg::LEN_W'(1);
		end else if (length_q > dfpm_pkg::LEN_W'(dfpm_pkg::PATTERN_MAX)) begin
			cfg.length = dfpm_pkg::LEN_W'(dfpm_pkg::PATTERN_MAX);
		end else begin
			cfg.length = length_q;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dfpm_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfpm_window
// Decides one end position: dilates per-symbol presence by the tolerance,
// aligns it to the offset and checks every pattern index against it.
// ----------------------------------------------------------------------------
module dfpm_window (
	input  wire dfpm_pkg::hist_t               hist,
	input  wire logic [dfpm_pkg::VCNT_W-1:0]   vcount,
	input  wire logic [dfpm_pkg::TOL_W-1:0]    off,
	input  wire dfpm_pkg::cfg_t                cfg,
	output logic                               start_ok,
	output logic                               matched
);

	logic [dfpm_pkg::NSYM-1:0][dfpm_pkg::HIST_DEPTH-1:0] pres;
	logic [dfpm_pkg::NSYM-1:0][dfpm_pkg::HIST_DEPTH-1:0] dil;
	logic [dfpm_pkg::NSYM-1:0][dfpm_pkg::HIST_DEPTH-1:0] algn;
	logic [dfpm_pkg::PATTERN_MAX-1:0]                    hit;
	logic [dfpm_pkg::OFFS_W-1:0]                         start_pos;

	always_comb begin
		for (int s = 0; s < dfpm_pkg::NSYM; s++) begin
			for (int d = 0; d < dfpm_pkg::HIST_DEPTH; d++) begin
				pres[s][d] = (dfpm_pkg::VCNT_W'(d) < vcount) &&
					(hist[d] == dfpm_pkg::SYM_W'(s));
			end
			dil[s] = pres[s];
			for (int k = 1; k <= dfpm_pkg::TOLERANCE_MAX; k++) begin
				if (dfpm_pkg::TOL_W'(k) <= cfg.tolerance) begin
					dil[s] = dil[s] | (pres[s] << k) | (pres[s] >> k);
				end
			end
			algn[s] = dil[s] >> off;
		end
	end

	always_comb begin
		logic [dfpm_pkg::LEN_W-1:0] ridx;
		logic [dfpm_pkg::SYM_W-1:0] want;
		ridx = '0;
		want = '0;
		for (int i = 0; i < dfpm_pkg::PATTERN_MAX; i++) begin
			ridx   = cfg.length - dfpm_pkg::LEN_W'(1) - dfpm_pkg::LEN_W'(i);
			want   = cfg.pattern[{ridx[dfpm_pkg::LEN_W-2:0], 1'b0} +: dfpm_pkg::SYM_W];
			hit[i] = (dfpm_pkg::LEN_W'(i) >= cfg.length) || algn[want][i];
		end
	end

	assign start_pos = dfpm_pkg::OFFS_W'(off) + dfpm_pkg::OFFS_W'(cfg.length)
		- dfpm_pkg::OFFS_W'(1);
	assign start_ok  = dfpm_pkg::OFFS_W'(vcount) > start_pos;
	assign matched   = &hit;

endmodule
`default_nettype wire

// File: hw/rtl/dfpm_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfpm_outq
// Two-entry result queue that decouples decisions from the output stream.
// ----------------------------------------------------------------------------
module dfpm_outq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dfpm_pkg::out_item_t  push_item,
	output logic                      space,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output dfpm_pkg::out_item_t       out_item
);

	dfpm_pkg::out_item_t entry_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;
	logic                pop;

	assign space     = cnt_q < 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/dna_fuzzy_pattern_matcher.sv
`default_nettype none
// A decision is registered in the decision stage and then in the result queue before
// it leaves; one symbol per cycle is taken while the queue has room and no flush runs.
// A final symbol stays in the decision stage while it flushes each end position, from
// offset tolerance down to zero, and then the summary; the input stalls until the summary.
// Reset clears history fill, text index, match count, queue; no clearing pass.
// ----------------------------------------------------------------------------
// dna_fuzzy_pattern_matcher
// Streams nucleotides, decides fuzzy pattern matches per end position and
// closes each text with a summary carrying the match total.
// ----------------------------------------------------------------------------
module dna_fuzzy_pattern_matcher (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [1:0] symbol
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [47:0]                   m_axis_tdata,  // end_position, matched, match_total
	output logic                               m_axis_tuser,  // has_position
	output logic                               m_axis_tlast,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dfpm_pkg::APB_AW-1:0]   paddr,
	input  wire logic [dfpm_pkg::APB_DW-1:0]   pwdata,
	output logic      [dfpm_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	localparam logic [dfpm_pkg::EPOS_W-1:0]  TEXT_LAST =
		dfpm_pkg::EPOS_W'(dfpm_pkg::TEXT_MAX - 1);
	localparam logic [dfpm_pkg::TOTAL_W-1:0] COUNT_MAX =
		dfpm_pkg::TOTAL_W'(dfpm_pkg::TEXT_MAX);
	localparam logic [dfpm_pkg::VCNT_W-1:0]  VCNT_FULL =
		dfpm_pkg::VCNT_W'(dfpm_pkg::HIST_DEPTH);

	dfpm_pkg::cfg_t      cfg;
	dfpm_pkg::hist_t     hist_q;
	dfpm_pkg::out_item_t item;
	dfpm_pkg::out_item_t q_item;

	logic [dfpm_pkg::VCNT_W-1:0]  vcount_q;
	logic [dfpm_pkg::EPOS_W-1:0]  text_index_q;
	logic [dfpm_pkg::TOTAL_W-1:0] match_count_q;
	logic [dfpm_pkg::TOTAL_W-1:0] mc_next;
	logic [dfpm_pkg::EPOS_W-1:0]  n_s1;
	logic [dfpm_pkg::EPOS_W-1:0]  back;
	logic [dfpm_pkg::TOL_W-1:0]   off_s1;
	logic                         pend_s1;
	logic                         fin_s1;
	logic                         summ_s1;

	logic acc;
	logic space;
	logic step;
	logic s1_done;
	logic clear_now;
	logic push;
	logic start_ok;
	logic matched;
	logic mc_inc;

	dfpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dfpm_window u_window (
		.hist     (hist_q),
		.vcount   (vcount_q),
		.off      (off_s1),
		.cfg      (cfg),
		.start_ok (start_ok),
		.matched  (matched)
	);

	assign step          = pend_s1 && space;
	assign s1_done       = step && (summ_s1 || !fin_s1);
	assign clear_now     = s1_done && fin_s1;
	assign s_axis_tready = !pend_s1 || s1_done;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign push          = step && (summ_s1 || start_ok);
	assign mc_inc        = step && !summ_s1 && start_ok && matched && (match_count_q < COUNT_MAX);
	assign mc_next       = match_count_q + dfpm_pkg::TOTAL_W'(mc_inc);
	assign back          = (n_s1 >= dfpm_pkg::EPOS_W'(off_s1)) ?
		dfpm_pkg::EPOS_W'(off_s1) : n_s1;

	always_comb begin
		if (summ_s1) begin
			item.end_position = '0;
			item.has_position = 1'b0;
			item.matched      = 1'b0;
			item.match_total  = match_count_q;
			item.last         = 1'b1;
		end else begin
			item.end_position = n_s1 - back;
			item.has_position = 1'b1;
			item.matched      = matched;
			item.match_total  = mc_next;
			item.last         = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q      <= '0;
			text_index_q  <= '0;
			match_count_q <= '0;
			pend_s1       <= 1'b0;
			fin_s1        <= 1'b0;
			summ_s1       <= 1'b0;
			off_s1        <= '0;
		end else begin
			if (clear_now) begin
				match_count_q <= '0;
			end else if (mc_inc) begin
				match_count_q <= mc_next;
			end

			if (acc) begin
				if (clear_now) begin
					vcount_q <= dfpm_pkg::VCNT_W'(1);
				end else if (vcount_q != VCNT_FULL) begin
					vcount_q <= vcount_q + dfpm_pkg::VCNT_W'(1);
				end
				if (s_axis_tlast) begin
					text_index_q <= '0;
				end else if (text_index_q < TEXT_LAST) begin
					text_index_q <= text_index_q + dfpm_pkg::EPOS_W'(1);
				end
			end else if (clear_now) begin
				vcount_q <= '0;
			end

			if (acc) begin
				pend_s1 <= 1'b1;
				fin_s1  <= s_axis_tlast;
				summ_s1 <= 1'b0;
				off_s1  <= cfg.tolerance;
			end else if (s1_done) begin
				pend_s1 <= 1'b0;
			end else if (step && fin_s1 && !summ_s1) begin
				if (off_s1 == '0) begin
					summ_s1 <= 1'b1;
				end else begin
					off_s1 <= off_s1 - dfpm_pkg::TOL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			hist_q <= {hist_q[dfpm_pkg::HIST_DEPTH-2:0], s_axis_tdata[dfpm_pkg::SYM_W-1:0]};
			n_s1   <= text_index_q;
		end
	end

	dfpm_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.space     (space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (q_item)
	);

	assign m_axis_tdata = {6'b0, q_item.match_total, q_item.matched, q_item.end_position};
	assign m_axis_tuser = q_item.has_position;
	assign m_axis_tlast = q_item.last;

`ifndef ASSERT_OFF
	a_summ_needs_fin: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && summ_s1 |-> fin_s1)
		else $error("summary phase without final symbol");
	a_acc_pends: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> pend_s1 && (vcount_q != '0))
		else $error("accepted symbol not pending or history empty");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		match_count_q <= COUNT_MAX)
		else $error("match count beyond saturation");
	a_flush_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 && fin_s1 && !s1_done |-> !s_axis_tready)
		else $error("input taken during flush");
`endif

endmodule
`default_nettype wire

// File: test/tb_dna_fuzzy_pattern_matcher.sv
// ----------------------------------------------------------------------------
// tb_dna_fuzzy_pattern_matcher
// Streams nucleotide texts into the fuzzy pattern matcher under random
// back-pressure on both sides and checks every decision and summary
// transfer against an in-bench prediction of the match window logic.
// ----------------------------------------------------------------------------
module tb_dna_fuzzy_pattern_matcher;
	timeunit 1ns;
	timeprecision 1ps;

	import dfpm_pkg::*;

	localparam int CYCLE_LIMIT   = 5_000_000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = TOLERANCE_MAX + 8;
	localparam int RANDOM_ITEMS  = 500;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             closing;
	} text_item_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	wire               s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0;   // [1:0] symbol
	logic              s_axis_tlast  = 1'b0;
	wire               m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	wire  [47:0]       m_axis_tdata;         // [19:0] end_position, [20] matched, [41:21] match_total
	wire               m_axis_tuser;         // has_position
	wire               m_axis_tlast;
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [APB_AW-1:0] paddr         = '0;
	logic [APB_DW-1:0] pwdata        = '0;
	wire  [APB_DW-1:0] prdata;
	wire               pready;

	dna_fuzzy_pattern_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// register shadow and predicted matcher state
	logic [LEN_W-1:0]   cfg_len = LEN_W'(1);
	logic [TOL_W-1:0]   cfg_tol = '0;
	logic [PAT_W-1:0]   cfg_pat = '0;
	logic [SYM_W-1:0]   hist_sym [HIST_DEPTH];
	bit                 hist_ok  [HIST_DEPTH];
	int unsigned        text_pos  = 0;
	int unsigned        hit_total = 0;

	text_item_t  text_queue[$];
	out_item_t   match_verdicts[$];

	int  fail_count     = 0;
	int  items_queued   = 0;
	int  items_accepted = 0;
	int  random_items   = 0;
	int  texts_closed   = 0;
	int  settings_used  = 0;
	int  decisions_seen = 0;
	int  matches_seen   = 0;
	int  summaries_seen = 0;
	int  cycle_count    = 0;
	int  send_gap       = 0;
	int  recv_stall     = 0;
	int  hold_left      = 0;
	int  hold_requests  = 0;
	int  hold_served    = 0;
	bit  send_calm      = 1'b0;
	bit  recv_calm      = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int draw_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 3)
			return $urandom_range(15, 50);
		if (r < 25)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	function automatic int eff_len();
		if (cfg_len == 0)
			return 1;
		if (int'(cfg_len) > PATTERN_MAX)
			return PATTERN_MAX;
		return int'(cfg_len);
	endfunction

	// -1: start before text, else 0/1 for the end position off steps back
	function automatic int window_hit(int off, int len, int tol);
		int         o;
		int         lo;
		int         hi;
		bit         found;
		logic [1:0] want;
		if (off + len - 1 >= HIST_DEPTH || !hist_ok[off + len - 1])
			return -1;
		for (int j = 0; j < len; j++) begin
			want  = cfg_pat[2*j +: 2];
			o     = off + len - 1 - j;
			lo    = (o >= tol) ? o - tol : 0;
			hi    = o + tol;
			found = 1'b0;
			for (int d = lo; d <= hi && d < HIST_DEPTH; d++) begin
				if (hist_ok[d] && hist_sym[d] == want)
					found = 1'b1;
			end
			if (!found)
				return 0;
		end
		return 1;
	endfunction

	task automatic advance_text(logic [SYM_W-1:0] sym, logic closing);
		int          len;
		int          tol;
		int          r;
		int unsigned n;
		out_item_t   res;
		len = eff_len();
		tol = (int'(cfg_tol) > TOLERANCE_MAX) ? TOLERANCE_MAX : int'(cfg_tol);
		n   = text_pos;
		for (int i = HIST_DEPTH - 1; i > 0; i--) begin
			hist_sym[i] = hist_sym[i-1];
			hist_ok[i]  = hist_ok[i-1];
		end
		hist_sym[0] = sym;
		hist_ok[0]  = 1'b1;
		for (int off = tol; off >= 0; off--) begin
			r = window_hit(off, len, tol);
			if (r >= 0) begin
				if (r == 1 && hit_total < TEXT_MAX)
					hit_total++;
				res.end_position = EPOS_W'(n - ((n >= off) ? off : n));
				res.has_position = 1'b1;
				res.matched      = (r == 1);
				res.match_total  = TOTAL_W'(hit_total);
				res.last         = 1'b0;
				match_verdicts.push_back(res);
			end
			if (!closing)
				break;
		end
		if (closing) begin
			res.end_position = '0;
			res.has_position = 1'b0;
			res.matched      = 1'b0;
			res.match_total  = TOTAL_W'(hit_total);
			res.last         = 1'b1;
			match_verdicts.push_back(res);
			foreach (hist_ok[i])
				hist_ok[i] = 1'b0;
			text_pos  = 0;
			hit_total = 0;
		end else if (text_pos < TEXT_MAX - 1) begin
			text_pos++;
		end
	endtask

	// sender
	always @(posedge clk) begin
		logic       offer;
		text_item_t pick;
		offer = s_axis_tvalid;
		pick  = '{sym: s_axis_tdata[SYM_W-1:0], closing: s_axis_tlast};
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_text(pick.sym, pick.closing);
				items_accepted++;
				offer    = 1'b0;
				send_gap = draw_gap(send_calm);
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (text_queue.size() > 0) begin
					pick  = text_queue.pop_front();
					offer = 1'b1;
				end
			end
		end
		s_axis_tvalid <= offer;
		s_axis_tdata  <= {6'b0, pick.sym};
		s_axis_tlast  <= pick.closing;
	end

	// receiver and checker
	always @(posedge clk) begin
		out_item_t res;
		logic      rdy;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (match_verdicts.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				res = match_verdicts.pop_front();
				if (m_axis_tdata[EPOS_W-1:0] !== res.end_position) begin
					$error("end_position: expected %0d, got %0d",
						res.end_position, m_axis_tdata[EPOS_W-1:0]);
					fail_count++;
				end
				if (m_axis_tuser !== res.has_position) begin
					$error("has_position: expected %0d, got %0d", res.has_position, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[EPOS_W] !== res.matched) begin
					$error("matched: expected %0d, got %0d", res.matched, m_axis_tdata[EPOS_W]);
					fail_count++;
				end
				if (m_axis_tdata[EPOS_W+1 +: TOTAL_W] !== res.match_total) begin
					$error("match_total: expected %0d, got %0d",
						res.match_total, m_axis_tdata[EPOS_W+1 +: TOTAL_W]);
					fail_count++;
				end
				if (m_axis_tlast !== res.last) begin
					$error("last: expected %0d, got %0d", res.last, m_axis_tlast);
					fail_count++;
				end
				if (res.has_position) begin
					decisions_seen++;
					if (res.matched)
						matches_seen++;
				end else begin
					summaries_seen++;
				end
			end
		end
		if (hold_served != hold_requests) begin
			hold_left   = HOLD_CYCLES;
			hold_served = hold_requests;
		end
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			rdy = 1'b0;
		end else begin
			rdy        = 1'b1;
			recv_stall = draw_gap(recv_calm);
		end
		m_axis_tready <= rdy;
	end

	task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PATTERN_LENGTH:  cfg_len = value[LEN_W-1:0];
			REG_TOLERANCE:       cfg_tol = value[TOL_W-1:0];
			REG_PATTERN_SYMBOLS: cfg_pat = value[PAT_W-1:0];
			default: ;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value) begin
			$error("register %0d readback: expected %0h, got %0h", idx, value, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(int len, int tol, logic [PAT_W-1:0] pat);
		write_reg(REG_PATTERN_LENGTH, APB_DW'(len));
		write_reg(REG_TOLERANCE, APB_DW'(tol));
		write_reg(REG_PATTERN_SYMBOLS, pat);
		settings_used++;
	endtask

	task automatic push_item(logic [SYM_W-1:0] sym, logic closing);
		text_queue.push_back('{sym: sym, closing: closing});
		items_queued++;
		if (closing)
			texts_closed++;
	endtask

	task automatic queue_text(int length, bit closing);
		logic [SYM_W-1:0] syms[$];
		int               plen;
		int               start;
		plen = eff_len();
		for (int i = 0; i < length; i++)
			syms.push_back(SYM_W'($urandom_range(0, 3)));
		if (length >= plen && $urandom_range(0, 3) != 0) begin
			start = $urandom_range(0, length - plen);
			for (int j = 0; j < plen; j++)
				syms[start + j] = cfg_pat[2*j +: 2];
			repeat ($urandom_range(0, 2))
				syms[$urandom_range(0, length - 1)] = SYM_W'($urandom_range(0, 3));
		end
		foreach (syms[i])
			push_item(syms[i], closing && i == length - 1);
		random_items += length;
	endtask

	task automatic settle();
		do @(posedge clk);
		while (items_accepted != items_queued || match_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return eff_len() + $urandom_range(0, 30);
		if (r < 93)
			return $urandom_range(1, eff_len() + 3);
		return $urandom_range(80, 150);
	endfunction

	initial begin
		int               phase;
		int               target;
		int               plen;
		int               ptol;
		logic [PAT_W-1:0] pat;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every symbol, then a closing symbol
		push_item(2'd0, 1'b0);
		push_item(2'd1, 1'b0);
		push_item(2'd2, 1'b0);
		push_item(2'd3, 1'b0);
		push_item(2'd3, 1'b1);
		settle();

		// text shorter than the pattern, then a one-symbol text
		configure(5, 2, {$urandom, $urandom});
		push_item(2'd1, 1'b0);
		push_item(2'd2, 1'b0);
		push_item(2'd0, 1'b1);
		push_item(2'd2, 1'b1);
		settle();

		// pattern A G C, tolerance one, with near hits
		configure(3, 1, 64'h24);
		push_item(2'd3, 1'b0);
		push_item(2'd0, 1'b0);
		push_item(2'd2, 1'b0);
		push_item(2'd1, 1'b0);
		push_item(2'd2, 1'b0);
		push_item(2'd0, 1'b0);
		push_item(2'd1, 1'b0);
		push_item(2'd3, 1'b0);
		push_item(2'd2, 1'b1);
		settle();

		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			pat = {$urandom, $urandom};
			case (phase)
				0: begin plen = PATTERN_MAX; ptol = TOLERANCE_MAX; end
				1: begin plen = 1;  ptol = 0;  pat = '0; end
				2: begin plen = 0;  ptol = 3;  end
				3: begin plen = 63; ptol = 1;  pat = '1; end
				4: begin plen = 16; ptol = TOLERANCE_MAX; end
				default: begin
					plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
						: $urandom_range(1, PATTERN_MAX);
					ptol = $urandom_range(0, TOLERANCE_MAX);
				end
			endcase
			configure(plen, ptol, pat);
			send_calm = (phase % 4 == 1);
			recv_calm = send_calm;
			if (phase == 0 || phase == 6)
				hold_requests++;
			target = random_items + 70;
			while (random_items < target)
				queue_text(pick_length(), 1'b1);
			// leave a text open across the next register change
			if (phase % 3 == 2)
				queue_text($urandom_range(1, 40), 1'b0);
			settle();
			phase++;
		end

		$display("ran %0d symbols in %0d texts over %0d register settings",
			items_accepted, texts_closed, settings_used);
		$display("compared %0d decisions (%0d matched) and %0d summaries",
			decisions_seen, matches_seen, summaries_seen);
		if (fail_count == 0 && match_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
